>>> src/blhm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blhm_pkg;

  localparam int WINDOW_SIZE = 16;
  localparam int WIN_LOG2    = $clog2(WINDOW_SIZE);
  localparam int SAMPLE_W    = 12;
  localparam int SUM_W       = $clog2(WINDOW_SIZE * 4095 + 1);
  localparam int THRESH_W    = 12;
  localparam int HYST_W      = 10;
  localparam int PERIOD_W    = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_THRESHOLD  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_THRESHOLD = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_PERIOD  = 8'd3;

  localparam logic [THRESH_W-1:0] HALF_THRESHOLD_RST  = 12'd2000;
  localparam logic [THRESH_W-1:0] EMPTY_THRESHOLD_RST = 12'd1800;
  localparam logic [HYST_W-1:0]   HYSTERESIS_RST      = 10'd60;
  localparam logic [PERIOD_W-1:0] MEASURE_PERIOD_RST  = 16'd999;

  localparam logic [0:0] CMD_SAMPLE = 1'b0;
  localparam logic [0:0] CMD_TICK   = 1'b1;

  typedef enum logic [1:0] {
    LEVEL_FULL  = 2'd0,
    LEVEL_HALF  = 2'd1,
    LEVEL_EMPTY = 2'd2
  } level_t;

  typedef struct packed {
    logic [THRESH_W-1:0] half_threshold;
    logic [THRESH_W-1:0] empty_threshold;
    logic [HYST_W-1:0]   hysteresis;
    logic [PERIOD_W-1:0] measure_period;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/blhm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module blhm_cell (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            shift,
  input  wire  [blhm_pkg::SAMPLE_W-1:0]  d,
  output logic [blhm_pkg::SAMPLE_W-1:0]  q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

>>> src/blhm_window.sv
`timescale 1ns / 1ps
`default_nettype none

module blhm_window (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            push,
  input  wire  [blhm_pkg::SAMPLE_W-1:0]  sample,
  output logic [blhm_pkg::SAMPLE_W-1:0]  mean
);

  logic [blhm_pkg::SAMPLE_W-1:0] taps [blhm_pkg::WINDOW_SIZE];
  logic [blhm_pkg::SUM_W-1:0]    window_sum;
  logic [blhm_pkg::SUM_W-1:0]    window_sum_next;

  for (genvar i = 0; i < blhm_pkg::WINDOW_SIZE; i++) begin : g_cell
    if (i == 0) begin : g_head
      blhm_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (push),
        .d     (sample),
        .q     (taps[i])
      );
    end else begin : g_body
      blhm_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (push),
        .d     (taps[i-1]),
        .q     (taps[i])
      );
    end
  end

  // The oldest sample leaves the last cell as the new one enters the first.
  assign window_sum_next = window_sum
                         - blhm_pkg::SUM_W'(taps[blhm_pkg::WINDOW_SIZE-1])
                         + blhm_pkg::SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
    end else if (push) begin
      window_sum <= window_sum_next;
    end
  end

  assign mean = blhm_pkg::SAMPLE_W'(window_sum >> blhm_pkg::WIN_LOG2);

endmodule

`default_nettype wire

>>> src/blhm_level.sv
`timescale 1ns / 1ps
`default_nettype none

module blhm_level (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            update,
  input  wire  [blhm_pkg::SAMPLE_W-1:0]  mean,
  input  blhm_pkg::cfg_t                 cfg,
  output blhm_pkg::level_t               level_next,
  output logic                           changed
);

  blhm_pkg::level_t            battery_level;
  logic [blhm_pkg::SAMPLE_W:0] half_up;
  logic [blhm_pkg::SAMPLE_W:0] empty_up;
  logic [blhm_pkg::SAMPLE_W:0] mean_ext;

  assign mean_ext = (blhm_pkg::SAMPLE_W + 1)'(mean);
  assign half_up  = (blhm_pkg::SAMPLE_W + 1)'(cfg.half_threshold)
                  + (blhm_pkg::SAMPLE_W + 1)'(cfg.hysteresis);
  assign empty_up = (blhm_pkg::SAMPLE_W + 1)'(cfg.empty_threshold)
                  + (blhm_pkg::SAMPLE_W + 1)'(cfg.hysteresis);

  always_comb begin
    level_next = battery_level;
    unique case (battery_level)
      blhm_pkg::LEVEL_FULL: begin
        if (mean < cfg.half_threshold) begin
          level_next = blhm_pkg::LEVEL_HALF;
        end
      end
      blhm_pkg::LEVEL_HALF: begin
        priority if (mean < cfg.empty_threshold) begin
          level_next = blhm_pkg::LEVEL_EMPTY;
        end else if (mean_ext > half_up) begin
          level_next = blhm_pkg::LEVEL_FULL;
        end else begin
          level_next = blhm_pkg::LEVEL_HALF;
        end
      end
      blhm_pkg::LEVEL_EMPTY: begin
        if (mean_ext > empty_up) begin
          level_next = blhm_pkg::LEVEL_HALF;
        end
      end
      default: begin
        level_next = battery_level;
      end
    endcase
  end

  assign changed = (level_next != battery_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_level <= blhm_pkg::LEVEL_FULL;
    end else if (update) begin
      battery_level <= level_next;
    end
  end

endmodule

`default_nettype wire

>>> src/battery_level_hysteresis_monitor_core.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | command, sample_value
// out     | output    | out_valid / out_ready| level, mean_value, level_changed
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A new word is accepted in each cycle while in_ready is high.
// A tick that ends a period loads the output register in the cycle it is accepted.
// Input stalls only while a result sits in the output register and out_ready is low.
// Reset clears the sample cells, the sum, the tick count and the level.
// The configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_hysteresis_monitor_core (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              command,
  input  wire  [blhm_pkg::SAMPLE_W-1:0]    sample_value,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [1:0]                       level,
  output logic [blhm_pkg::SAMPLE_W-1:0]    mean_value,
  output logic                             level_changed,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [blhm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [blhm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  blhm_pkg::cfg_t                cfg;
  blhm_pkg::level_t              level_next;
  logic                          changed;
  logic [blhm_pkg::SAMPLE_W-1:0] mean;
  logic [blhm_pkg::PERIOD_W-1:0] tick_count;
  logic [blhm_pkg::PERIOD_W-1:0] tick_count_next;
  logic                          in_fire;
  logic                          push;
  logic                          tick;
  logic                          measure;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign push      = in_fire && (command == blhm_pkg::CMD_SAMPLE);
  assign tick      = in_fire && (command == blhm_pkg::CMD_TICK);

  assign tick_count_next = tick_count + 1'b1;
  assign measure         = tick && (tick_count_next >= cfg.measure_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_threshold  <= blhm_pkg::HALF_THRESHOLD_RST;
      cfg.empty_threshold <= blhm_pkg::EMPTY_THRESHOLD_RST;
      cfg.hysteresis      <= blhm_pkg::HYSTERESIS_RST;
      cfg.measure_period  <= blhm_pkg::MEASURE_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        blhm_pkg::REG_HALF_THRESHOLD:
          cfg.half_threshold <= cfg_data[blhm_pkg::THRESH_W-1:0];
        blhm_pkg::REG_EMPTY_THRESHOLD:
          cfg.empty_threshold <= cfg_data[blhm_pkg::THRESH_W-1:0];
        blhm_pkg::REG_HYSTERESIS:
          cfg.hysteresis <= cfg_data[blhm_pkg::HYST_W-1:0];
        blhm_pkg::REG_MEASURE_PERIOD:
          cfg.measure_period <= cfg_data[blhm_pkg::PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (measure) begin
      tick_count <= '0;
    end else if (tick) begin
      tick_count <= tick_count_next;
    end
  end

  blhm_window u_window (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .sample (sample_value),
    .mean   (mean)
  );

  blhm_level u_level (
    .clk        (clk),
    .rst        (rst),
    .update     (measure),
    .mean       (mean),
    .cfg        (cfg),
    .level_next (level_next),
    .changed    (changed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= measure;
    end
  end

  always_ff @(posedge clk) begin
    if (measure) begin
      level         <= 2'(level_next);
      mean_value    <= mean;
      level_changed <= changed;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled with an empty output register.");

  a_sample_no_result: assert property (@(posedge clk) disable iff (rst)
    push |=> !out_valid)
    else $error("A sample word produced a result.");

  a_measure_result: assert property (@(posedge clk) disable iff (rst)
    measure |=> out_valid && (mean_value == $past(mean)))
    else $error("A measurement did not load the output register.");

  a_tick_count_cleared: assert property (@(posedge clk) disable iff (rst)
    measure |=> tick_count == '0)
    else $error("Tick count not cleared after a measurement.");

endmodule

`default_nettype wire
